// ===== sv/infix_to_postfix_converter_core_defines.svh =====
// Assertion macros for the RTL; itp_ctrl includes them.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ITP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ITP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

  localparam int StackDepth = 32;
  localparam int AddrW      = $clog2(StackDepth);
  localparam int CountW     = $clog2(StackDepth + 1);
  localparam int SymW       = 3;

  typedef enum logic [1:0] {
    StToken          = 2'd0,
    StOverflow       = 2'd1,
    StUnmatchedClose = 2'd2,
    StUnmatchedOpen  = 2'd3
  } status_e;

  typedef enum logic [SymW-1:0] {
    SymOpen  = 3'd0,
    SymPlus  = 3'd1,
    SymMinus = 3'd2,
    SymMul   = 3'd3,
    SymDiv   = 3'd4,
    SymPow   = 3'd5
  } sym_e;

  typedef enum logic [2:0] {
    ClsOperand = 3'd0,
    ClsOper    = 3'd1,
    ClsOpen    = 3'd2,
    ClsClose   = 3'd3,
    ClsOther   = 3'd4
  } cls_e;

  localparam logic [7:0] ChDigitLo = 8'd48;
  localparam logic [7:0] ChDigitHi = 8'd57;
  localparam logic [7:0] ChLowerLo = 8'd97;
  localparam logic [7:0] ChLowerHi = 8'd122;
  localparam logic [7:0] ChOpen    = 8'h28;
  localparam logic [7:0] ChClose   = 8'h29;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChMul     = 8'h2a;
  localparam logic [7:0] ChDiv     = 8'h2f;
  localparam logic [7:0] ChPow     = 8'h5e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_token;
    status_e    status;
    logic       last_of_run;
    logic       end_of_expression;
  } out_word_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [SymW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  function automatic cls_e char_class(logic [7:0] c);
    cls_e cls;
    cls = ClsOther;
    if ((c >= ChDigitLo && c <= ChDigitHi) || (c >= ChLowerLo && c <= ChLowerHi)) begin
      cls = ClsOperand;
    end else if (c == ChPlus || c == ChMinus || c == ChMul || c == ChDiv || c == ChPow) begin
      cls = ClsOper;
    end else if (c == ChOpen) begin
      cls = ClsOpen;
    end else if (c == ChClose) begin
      cls = ClsClose;
    end
    return cls;
  endfunction

  function automatic sym_e char_sym(logic [7:0] c);
    sym_e s;
    unique case (c)
      ChPlus:  s = SymPlus;
      ChMinus: s = SymMinus;
      ChMul:   s = SymMul;
      ChDiv:   s = SymDiv;
      ChPow:   s = SymPow;
      default: s = SymOpen;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] sym_char(sym_e s);
    logic [7:0] c;
    unique case (s)
      SymOpen:  c = ChOpen;
      SymPlus:  c = ChPlus;
      SymMinus: c = ChMinus;
      SymMul:   c = ChMul;
      SymDiv:   c = ChDiv;
      SymPow:   c = ChPow;
      default:  c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] sym_prec(sym_e s);
    logic [1:0] p;
    unique case (s) inside
      SymPlus, SymMinus: p = 2'd1;
      SymMul, SymDiv:    p = 2'd2;
      SymPow:            p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/itp_stack_ram.sv =====
`timescale 1ns / 1ps

module itp_stack_ram #(
  parameter int Depth = 32,
  parameter int Width = 3,
  localparam int AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Write-first: a read of the entry being written returns the new data.
  always_ff @(posedge clk_i) begin
    if (we_i && waddr_i == raddr_i) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/itp_ctrl.sv =====
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_core_defines.svh"

module itp_ctrl import itp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_word_i,
  input  logic            out_free_i,
  output logic            out_push_o,
  output out_word_t       out_word_o,
  output ram_req_t        ram_req_o,
  input  logic [SymW-1:0] rd_data_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ACT   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [CountW-1:0] CountFull = CountW'(StackDepth);

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              hold_v_q, hold_v_d;
  out_word_t         hold_q, hold_d;
  logic [7:0]        char_q;
  logic              last_q;
  cls_e              cls_q;
  sym_e              code_q;

  logic      emit_req, do_push, do_pop, adv, go;
  out_word_t emit_word;
  sym_e      top_sym;
  logic [1:0] in_prec, top_prec;
  logic [1:0] adv_st;

  assign top_sym    = sym_e'(rd_data_i);
  assign in_prec    = sym_prec(code_q);
  assign top_prec   = sym_prec(top_sym);
  assign adv_st     = last_q ? S_FLUSH : S_DONE;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    emit_req   = 1'b0;
    emit_word  = '0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    adv        = 1'b0;
    out_push_o = 1'b0;
    out_word_o = hold_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        case (cls_q)
          ClsOperand: begin
            emit_req  = 1'b1;
            emit_word = '{out_token: char_q, status: StToken, default: '0};
            adv       = 1'b1;
          end
          ClsOper: begin
            if (code_q != SymPow && cnt_q != '0 && top_sym != SymOpen
                && top_prec >= in_prec) begin
              emit_req  = 1'b1;
              emit_word = '{out_token: sym_char(top_sym), status: StToken, default: '0};
              do_pop    = 1'b1;
            end else if (cnt_q >= CountFull) begin
              emit_req  = 1'b1;
              emit_word = '{out_token: char_q, status: StOverflow, default: '0};
              adv       = 1'b1;
            end else begin
              do_push = 1'b1;
              adv     = 1'b1;
            end
          end
          ClsOpen: begin
            if (cnt_q >= CountFull) begin
              emit_req  = 1'b1;
              emit_word = '{out_token: char_q, status: StOverflow, default: '0};
            end else begin
              do_push = 1'b1;
            end
            adv = 1'b1;
          end
          ClsClose: begin
            if (cnt_q != '0) begin
              do_pop = 1'b1;
              if (top_sym == SymOpen) begin
                adv = 1'b1;
              end else begin
                emit_req  = 1'b1;
                emit_word = '{out_token: sym_char(top_sym), status: StToken, default: '0};
              end
            end else begin
              emit_req  = 1'b1;
              emit_word = '{out_token: char_q, status: StUnmatchedClose, default: '0};
              adv       = 1'b1;
            end
          end
          default: adv = 1'b1;
        endcase
      end
      S_FLUSH: begin
        if (cnt_q != '0) begin
          emit_req = 1'b1;
          do_pop   = 1'b1;
          if (top_sym == SymOpen) begin
            emit_word = '{out_token: ChOpen, status: StUnmatchedOpen, default: '0};
          end else begin
            emit_word = '{out_token: sym_char(top_sym), status: StToken, default: '0};
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Release the held word as the final one of this character.
        if (hold_v_q) begin
          if (out_free_i) begin
            out_push_o                   = 1'b1;
            out_word_o.last_of_run       = 1'b1;
            out_word_o.end_of_expression = last_q;
            hold_v_d                     = 1'b0;
            state_d                      = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A new word displaces the held one, which then is known not to be final.
    go = !emit_req || !hold_v_q || out_free_i;
    if (go) begin
      if (do_push) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (do_pop) begin
        cnt_d = cnt_q - 1'b1;
      end
      if (adv) begin
        state_d = adv_st;
      end
      if (emit_req) begin
        if (hold_v_q) begin
          out_push_o = 1'b1;
        end
        hold_d   = emit_word;
        hold_v_d = 1'b1;
      end
    end
  end

  // Keep the read address one below the next count so the top is always ready.
  always_comb begin
    ram_req_o.we    = do_push && go;
    ram_req_o.waddr = AddrW'(cnt_q);
    ram_req_o.wdata = code_q;
    ram_req_o.raddr = (cnt_d == '0) ? '0 : AddrW'(cnt_d - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (in_valid_i && in_ready_o) begin
      char_q <= in_word_i.in_char;
      last_q <= in_word_i.is_last;
      cls_q  <= char_class(in_word_i.in_char);
      code_q <= char_sym(in_word_i.in_char);
    end
  end

  `ITP_ASSERT_NEVER(a_cnt_range, cnt_q > CountFull, "stack count beyond depth")
  `ITP_ASSERT_IMP(a_push_room, ram_req_o.we, cnt_q < CountFull, "push into full stack")
  `ITP_ASSERT_IMP(a_push_free, out_push_o, out_free_i, "word pushed into busy output")
  `ITP_ASSERT_IMP(a_idle_hold, state_q == S_IDLE, !hold_v_q, "held word left in idle")
  `ITP_ASSERT_NEXT(a_accept_act, in_valid_i && in_ready_o, state_q == S_ACT, "accept lost")

endmodule

// ===== sv/infix_to_postfix_converter_core.sv =====
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. One ASCII character enters per
// accepted in_word; operands leave at once, operators wait on a 32-entry stack
// held in a synchronous RAM and leave as postfix tokens, with status codes for
// overflow and unmatched parentheses. A character is taken while idle; the
// active state then pushes it or pops one operator per pass (a matching '('
// is dropped on its last pass), and a last character flushes the stack before
// the done state. The pop loop runs one entry a cycle because the RAM read port
// always prefetches the entry below the next stack count. Each character's last
// word is held back to mark last_of_run, and back-pressure stalls the pop loop.
module infix_to_postfix_converter_core import itp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  ram_req_t        ram_req;
  logic [SymW-1:0] rd_data;
  logic            out_free, out_push;
  out_word_t       push_word;
  logic            out_valid_q;
  out_word_t       out_word_q;

  assign out_free = !out_valid_q || out_ready_i;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_free_i (out_free),
    .out_push_o (out_push),
    .out_word_o (push_word),
    .ram_req_o  (ram_req),
    .rd_data_i  (rd_data)
  );

  itp_stack_ram #(
    .Depth (StackDepth),
    .Width (SymW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_word_q <= push_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
